// ===== rtl/core/lcs_pkg.sv =====
// Shared types and constants for the largest-component search block.
// Used by lcs_ctrl, lcs_datapath and largest_component_size; no dependencies.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;
  localparam int COUNT_W   = 7;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic       REG_NODE_COUNT = 1'b0;
  localparam logic [6:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_INIT,
    ST_SCAN,
    ST_POP,
    ST_ROW_RD,
    ST_EXPAND,
    ST_DONE
  } lcs_state_t;

  typedef struct packed {
    logic latch_edge;
    logic adj_clear;
    logic rd_row_a;
    logic rd_row_b;
    logic rd_row_top;
    logic wr_row_a;
    logic wr_row_b;
    logic search_init;
    logic scan_next;
    logic scan_start;
    logic pop;
    logic push_cand;
    logic comp_done;
    logic out_load;
  } lcs_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic scan_end;
    logic scan_visited;
    logic stack_empty;
    logic cand_none;
    logic out_busy;
  } lcs_status_t;

endpackage

// ===== rtl/core/largest_component_size.sv =====
// Top level of the largest-component search block: APB register, controller
// and datapath. Depends on lcs_pkg, lcs_ctrl and lcs_datapath.
`timescale 1ns / 1ps

// Holds an undirected graph of up to 64 nodes as a symmetric adjacency matrix
// and answers, per search request, with the node count of its largest connected
// component. An add-edge request is accepted and then does a read-modify-write
// of each of the two rows in the adjacency memory; an edge with an endpoint at
// or above node_count is dropped at acceptance. A clear request completes in
// the cycle it is accepted. A search is accepted and initialised, then the node
// scan takes each node in turn; from each unvisited node a walk repeatedly pops
// a node, reads its row and pushes its unvisited neighbors one at a time until
// the row is exhausted, each component ends on an empty stack, and the end of
// the scan is followed by the result load. A search result waits in the output
// register; the block takes no new request from the search start until the
// result is loaded, which slips while an earlier result is still held.
// node_count lies at address 0 and is used saturated at 64.
module largest_component_size (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [5:0]  node_a,
  input  logic [5:0]  node_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  largest_size
);

  logic [lcs_pkg::COUNT_W-1:0] node_count;
  lcs_pkg::lcs_cmd_t           cmd;
  lcs_pkg::lcs_status_t        status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= lcs_pkg::NODE_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == lcs_pkg::REG_NODE_COUNT)) begin
      node_count <= pwdata[lcs_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lcs_pkg::REG_NODE_COUNT) ?
                  {{(32 - lcs_pkg::COUNT_W){1'b0}}, node_count} : '0;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lcs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .node_a       (node_a),
    .node_b       (node_b),
    .node_count   (node_count),
    .out_ready    (out_ready),
    .status       (status),
    .out_valid    (out_valid),
    .largest_size (largest_size)
  );

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (largest_size <= 7'd64))
    else $error("largest_size above node limit");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (req_type == lcs_pkg::REQ_SEARCH)) |=> !in_ready)
    else $error("request taken during search");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while idle");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_start, cmd.push_cand, cmd.pop, cmd.comp_done, cmd.scan_next}))
    else $error("conflicting stack commands");

endmodule

// ===== rtl/core/lcs_ctrl.sv =====
// Controller state machine for the largest-component search block.
// Depends on lcs_pkg for the state enum, request codes and command/status structs.
`timescale 1ns / 1ps

module lcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           req_type,
  input  lcs_pkg::lcs_status_t status,
  output logic                 in_ready,
  output lcs_pkg::lcs_cmd_t    cmd
);

  lcs_pkg::lcs_state_t state;
  lcs_pkg::lcs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_edge = 1'b1;
          case (req_type)
            lcs_pkg::REQ_ADD: begin
              if (status.edge_ok) state_next = lcs_pkg::ST_ADD_RD_A;
            end
            lcs_pkg::REQ_SEARCH: state_next = lcs_pkg::ST_INIT;
            lcs_pkg::REQ_CLEAR:  cmd.adj_clear = 1'b1;
            default: ;
          endcase
        end
      end
      lcs_pkg::ST_ADD_RD_A: begin
        cmd.rd_row_a = 1'b1;
        state_next   = lcs_pkg::ST_ADD_WR_A;
      end
      lcs_pkg::ST_ADD_WR_A: begin
        cmd.wr_row_a = 1'b1;
        state_next   = lcs_pkg::ST_ADD_RD_B;
      end
      lcs_pkg::ST_ADD_RD_B: begin
        cmd.rd_row_b = 1'b1;
        state_next   = lcs_pkg::ST_ADD_WR_B;
      end
      lcs_pkg::ST_ADD_WR_B: begin
        cmd.wr_row_b = 1'b1;
        state_next   = lcs_pkg::ST_IDLE;
      end
      lcs_pkg::ST_INIT: begin
        cmd.search_init = 1'b1;
        state_next      = lcs_pkg::ST_SCAN;
      end
      lcs_pkg::ST_SCAN: begin
        if (status.scan_end) begin
          state_next = lcs_pkg::ST_DONE;
        end else if (status.scan_visited) begin
          cmd.scan_next = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = lcs_pkg::ST_POP;
        end
      end
      lcs_pkg::ST_POP: begin
        if (status.stack_empty) begin
          cmd.comp_done = 1'b1;
          state_next    = lcs_pkg::ST_SCAN;
        end else begin
          cmd.pop    = 1'b1;
          state_next = lcs_pkg::ST_ROW_RD;
        end
      end
      lcs_pkg::ST_ROW_RD: begin
        cmd.rd_row_top = 1'b1;
        state_next     = lcs_pkg::ST_EXPAND;
      end
      lcs_pkg::ST_EXPAND: begin
        // push one unvisited neighbor per cycle until the row is exhausted
        if (status.cand_none) begin
          state_next = lcs_pkg::ST_POP;
        end else begin
          cmd.push_cand = 1'b1;
        end
      end
      lcs_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = lcs_pkg::ST_IDLE;
        end
      end
      default: state_next = lcs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/lcs_datapath.sv =====
// Datapath for the largest-component search: adjacency memory, walk stack,
// visited set, counters and the result register. Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lcs_pkg::lcs_cmd_t             cmd,
  input  logic [lcs_pkg::NODE_W-1:0]    node_a,
  input  logic [lcs_pkg::NODE_W-1:0]    node_b,
  input  logic [lcs_pkg::COUNT_W-1:0]   node_count,
  input  logic                          out_ready,
  output lcs_pkg::lcs_status_t          status,
  output logic                          out_valid,
  output logic [lcs_pkg::COUNT_W-1:0]   largest_size
);

  localparam int N  = lcs_pkg::MAX_NODES;
  localparam int NW = lcs_pkg::NODE_W;
  localparam int CW = lcs_pkg::COUNT_W;

  logic [N-1:0]  adj_mem [N];
  logic [N-1:0]  row_valid;
  logic [N-1:0]  row_data;
  logic          row_hit;
  logic [N-1:0]  row_word;

  logic [NW-1:0] stack_mem [N];
  logic [NW-1:0] stack_top;

  logic [NW-1:0] edge_a;
  logic [NW-1:0] edge_b;

  logic [N-1:0]  visited;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] depth;
  logic [CW-1:0] comp;
  logic [CW-1:0] best;

  logic [CW-1:0] active;
  logic [N-1:0]  node_mask;
  logic [N-1:0]  cand;
  logic [N-1:0]  cand_low;
  logic [NW-1:0] cand_idx;

  logic          rd_en;
  logic [NW-1:0] rd_addr;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  logic [NW-1:0] wr_bit;
  logic [N-1:0]  wr_data;

  // Saturate the configured count at the matrix size.
  assign active = (node_count > CW'(N)) ? CW'(N) : node_count;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      node_mask[i] = (CW'(i) < active);
    end
  end

  // Adjacency memory: one registered read, one write per cycle.
  assign rd_en   = cmd.rd_row_a | cmd.rd_row_b | cmd.rd_row_top;
  assign rd_addr = cmd.rd_row_a ? edge_a : (cmd.rd_row_b ? edge_b : stack_top);
  assign wr_en   = cmd.wr_row_a | cmd.wr_row_b;
  assign wr_addr = cmd.wr_row_a ? edge_a : edge_b;
  assign wr_bit  = cmd.wr_row_a ? edge_b : edge_a;
  assign row_word = row_hit ? row_data : '0;
  assign wr_data  = row_word | (N'(1) << wr_bit);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      row_data <= adj_mem[rd_addr];
    end
  end

  // A row that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_hit   <= 1'b0;
    end else begin
      if (cmd.adj_clear) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        row_hit <= row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_edge) begin
      edge_a <= node_a;
      edge_b <= node_b;
    end
  end

  // Unvisited neighbors of the popped node; pick the lowest one.
  assign cand     = row_word & ~visited & node_mask;
  assign cand_low = cand & (~cand + N'(1));

  always_comb begin
    cand_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (cand_low[i]) cand_idx = cand_idx | NW'(i);
    end
  end

  // Walk stack memory.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      stack_mem[depth[NW-1:0]] <= scan_idx[NW-1:0];
    end else if (cmd.push_cand) begin
      stack_mem[depth[NW-1:0]] <= cand_idx;
    end
    if (cmd.pop) begin
      stack_top <= stack_mem[NW'(depth - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited  <= '0;
      scan_idx <= '0;
      depth    <= '0;
      comp     <= '0;
      best     <= '0;
    end else begin
      if (cmd.search_init) begin
        visited  <= '0;
        scan_idx <= '0;
        depth    <= '0;
        best     <= '0;
      end
      if (cmd.scan_next) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (cmd.scan_start) begin
        visited[scan_idx[NW-1:0]] <= 1'b1;
        depth <= depth + CW'(1);
        comp  <= '0;
      end
      if (cmd.push_cand) begin
        visited[cand_idx] <= 1'b1;
        depth <= depth + CW'(1);
      end
      if (cmd.pop) begin
        depth <= depth - CW'(1);
        comp  <= comp + CW'(1);
      end
      if (cmd.comp_done) begin
        if (comp > best) best <= comp;
        scan_idx <= scan_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      largest_size <= best;
    end
  end

  always_comb begin
    status.edge_ok      = ({1'b0, node_a} < active) && ({1'b0, node_b} < active);
    status.scan_end     = (scan_idx >= active);
    status.scan_visited = visited[scan_idx[NW-1:0]];
    status.stack_empty  = (depth == '0);
    status.cand_none    = (cand == '0);
    status.out_busy     = out_valid && !out_ready;
  end

endmodule

// ===== tb/sv/tb_largest_component_size.sv =====
`timescale 1ns / 1ps
// Testbench for largest_component_size: drives edge, clear and search requests
// plus node_count writes, predicts each search result and checks it in order.
// Depends on lcs_pkg and the largest_component_size RTL.

module tb_largest_component_size;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam logic [2:0] ADDR_NODE_COUNT = {lcs_pkg::REG_NODE_COUNT, 2'b00};
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         STALL_LIMIT     = 4000;
  localparam int         PHASE_ITEMS     = 317;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = lcs_pkg::REQ_ADD;
  logic [5:0]  node_a = '0;
  logic [5:0]  node_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  largest_size;

  // Predicted graph state and the queue of search sizes still to come
  logic [63:0] adj_rows [lcs_pkg::MAX_NODES];
  logic [6:0]  node_count_cfg;
  logic [6:0]  expected_sizes [$];
  logic [6:0]  want;

  int fail_count = 0;
  int results_checked = 0;
  int items_counted = 0;
  int reg_writes = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  largest_component_size dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .node_a(node_a), .node_b(node_b),
    .out_valid(out_valid), .out_ready(out_ready), .largest_size(largest_size)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_nodes();
    return (node_count_cfg > 7'd64) ? lcs_pkg::MAX_NODES : int'(node_count_cfg);
  endfunction

  function automatic void reset_model();
    foreach (adj_rows[r]) adj_rows[r] = '0;
    node_count_cfg = lcs_pkg::NODE_COUNT_RST;
    expected_sizes.delete();
  endfunction

  // Walk every component from its lowest unvisited node; keep the largest count
  function automatic logic [6:0] largest_component();
    logic [63:0] seen;
    int pending [$];
    int n, s, i, v, cnt, best;
    n = active_nodes();
    seen = '0;
    best = 0;
    for (s = 0; s < n; s++) begin
      if (!seen[s]) begin
        seen[s] = 1'b1;
        pending = {pending, s};
        cnt = 0;
        while (pending.size() != 0) begin
          v = pending.pop_back();
          cnt++;
          for (i = 0; i < n; i++) begin
            if (adj_rows[v][i] && !seen[i]) begin
              seen[i] = 1'b1;
              pending = {pending, i};
            end
          end
        end
        if (cnt > best) best = cnt;
      end
    end
    return best[6:0];
  endfunction

  // Returns 1 for a search, a clear or an edge with both ends in range
  function automatic bit apply_request(logic [1:0] kind, logic [5:0] a, logic [5:0] b);
    int n;
    n = active_nodes();
    case (kind)
      lcs_pkg::REQ_ADD: begin
        if (a < n && b < n) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
          return 1'b1;
        end
      end
      lcs_pkg::REQ_SEARCH: begin
        expected_sizes = {expected_sizes, largest_component()};
        return 1'b1;
      end
      lcs_pkg::REQ_CLEAR: begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [5:0] a,
                              input logic [5:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    node_a   <= a;
    node_b   <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (apply_request(kind, a, b)) items_counted++;
  endtask

  // Drop valid, wait out every pending search, then let any edge update finish
  task automatic hold_until_idle();
    in_valid <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_NODE_COUNT) node_count_cfg = value;
    reg_writes++;
  endtask

  task automatic test_empty_graph();
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  task automatic test_self_loop();
    send_request(lcs_pkg::REQ_ADD, 6'd5, 6'd5);
    send_request(lcs_pkg::REQ_SEARCH, 6'd63, 6'd63);
  endtask

  task automatic test_extreme_nodes();
    send_request(lcs_pkg::REQ_ADD, 6'd0, 6'd63);
    send_request(lcs_pkg::REQ_ADD, 6'd63, 6'd62);
    send_request(lcs_pkg::REQ_ADD, 6'd62, 6'd0);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  task automatic test_unused_request();
    send_request(REQ_UNUSED, 6'd63, 6'd1);
    send_request(REQ_UNUSED, 6'd2, 6'd63);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  task automatic test_clear_graph();
    send_request(lcs_pkg::REQ_CLEAR, 6'd63, 6'd63);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  task automatic test_node_count_limits();
    // no nodes at all
    hold_until_idle();
    write_register(ADDR_NODE_COUNT, 7'd0);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
    hold_until_idle();
    write_register(ADDR_NODE_COUNT, 7'd1);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
    // count above the node limit saturates
    hold_until_idle();
    write_register(ADDR_NODE_COUNT, 7'd127);
    send_request(lcs_pkg::REQ_ADD, 6'd0, 6'd1);
    send_request(lcs_pkg::REQ_ADD, 6'd1, 6'd2);
    send_request(lcs_pkg::REQ_ADD, 6'd2, 6'd63);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
    // shrink below stored edges, then add an edge that lies outside
    hold_until_idle();
    write_register(ADDR_NODE_COUNT, 7'd2);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
    send_request(lcs_pkg::REQ_ADD, 6'd1, 6'd5);
    hold_until_idle();
    write_register(ADDR_NODE_COUNT, 7'd64);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  task automatic test_register_index();
    hold_until_idle();
    write_register(ADDR_UNUSED, 7'd3);
    send_request(lcs_pkg::REQ_SEARCH, 6'd0, 6'd0);
  endtask

  // Episodes of optional clear, windowed edges (or a full path), then search
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int quota);
    int first, n, lo, w, edges, pick, i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = items_counted;
    while (items_counted - first < quota) begin
      if ($urandom_range(3) == 0) begin
        pick = $urandom_range(9);
        hold_until_idle();
        case (pick)
          0: write_register(ADDR_NODE_COUNT, 7'd1);
          1: write_register(ADDR_NODE_COUNT, 7'd64);
          2: write_register(ADDR_NODE_COUNT, 7'($urandom_range(65, 127)));
          3: write_register(ADDR_NODE_COUNT, 7'd2);
          default: write_register(ADDR_NODE_COUNT, 7'($urandom_range(1, 64)));
        endcase
      end
      n = active_nodes();
      if ($urandom_range(2) == 0)
        send_request(lcs_pkg::REQ_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)));
      if (n > 1 && $urandom_range(11) == 0) begin
        for (i = 0; i < n - 1; i++) send_request(lcs_pkg::REQ_ADD, 6'(i), 6'(i + 1));
      end else begin
        lo = $urandom_range(0, n - 1);
        w = $urandom_range(1, n - lo);
        edges = $urandom_range(0, (w < 12) ? w + 2 : 14);
        repeat (edges) begin
          case ($urandom_range(15))
            0: send_request(REQ_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)));
            1, 2: send_request(lcs_pkg::REQ_ADD, 6'($urandom_range(63)),
                               6'($urandom_range(63)));
            default: send_request(lcs_pkg::REQ_ADD, 6'(lo + $urandom_range(0, w - 1)),
                                  6'(lo + $urandom_range(0, w - 1)));
          endcase
        end
      end
      send_request(lcs_pkg::REQ_SEARCH, 6'($urandom_range(63)), 6'($urandom_range(63)));
    end
  endtask

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sizes.size() == 0) begin
        $error("largest_size: unexpected result %0d", largest_size);
        fail_count++;
      end else begin
        want = expected_sizes.pop_front();
        results_checked++;
        if (largest_size !== want) begin
          $error("largest_size: expected %0d, got %0d", want, largest_size);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $error("timeout: no handshake for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_empty_graph();
    test_self_loop();
    test_extreme_nodes();
    test_unused_request();
    test_clear_graph();
    test_node_count_limits();
    test_register_index();
    run_random_phase(35, 73, PHASE_ITEMS);
    run_random_phase(73, 35, PHASE_ITEMS);
    run_random_phase(0, 0, PHASE_ITEMS);
    hold_until_idle();
    $display("Checked %0d search results over %0d requests and %0d register writes",
             results_checked, items_counted, reg_writes);
    $display("Node counts 0 to 127, full-path graphs, three sender/receiver stall mixes");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lcs_pkg.sv
rtl/core/lcs_ctrl.sv
rtl/core/lcs_datapath.sv
rtl/core/largest_component_size.sv
tb/sv/tb_largest_component_size.sv
